/* sv/lrbq_pkg.sv */
// Package for the length-prefixed byte ring queue.
// Holds request and status codes, sequencer states and parameter defaults.
// No dependencies.
package lrbq_pkg;

  // Default sizes, handed to the top level's parameters.
  localparam int unsigned RING_BYTES_DEF = 4096;
  localparam int unsigned MAX_MSG_DEF    = 1024;

  // Field widths fixed by the interface.
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned LEN_IN_W = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STS_W    = 3;

  // Request codes carried on s_tuser.
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd2;

  // Status codes carried on m_tuser.
  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_FULL      = 3'd1;
  localparam logic [STS_W-1:0] STS_TOO_LARGE = 3'd2;
  localparam logic [STS_W-1:0] STS_INVALID   = 3'd3;
  localparam logic [STS_W-1:0] STS_EMPTY     = 3'd4;
  localparam logic [STS_W-1:0] STS_BAD_SIZE  = 3'd5;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_HDR_WR,
    S_HDR_RD,
    S_DATA_RD
  } state_t;

endpackage

/* sv/length_prefixed_byte_ring_queue.sv */
// Push byte, empty pop and every rejected request give their word in the cycle after
// acceptance, and so does an accepted start push, which then writes the remaining three
// header bytes in S_HDR_WR. A pop inside an open message reads its byte in S_DATA_RD; the
// first pop of a message reads four header bytes in S_HDR_RD and then its first byte.
// Throughput: a push byte every cycle while the sink keeps up; s_tready is low outside S_IDLE.
// Reset clears pointers, counters and the output valid flag; the ring memory is not cleared.
// Length-prefixed byte ring queue, top level: sequencer around one byte-wide ring memory.
// Depends on lrbq_pkg.
module length_prefixed_byte_ring_queue
  import lrbq_pkg::*;
#(
  parameter int unsigned RING_BYTES        = RING_BYTES_DEF,
  parameter int unsigned MAX_MESSAGE_BYTES = MAX_MSG_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  input  logic [23:0] s_tdata,   // msg_len[15:0], data_byte[23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic [23:0] m_tdata,   // pop_byte[7:0], pop_len[23:8]
  output logic        m_tlast    // pop_last
);

  localparam int unsigned PTR_W = $clog2(RING_BYTES);
  localparam int unsigned LEN_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int unsigned SUM_W = ((PTR_W > LEN_IN_W) ? PTR_W : LEN_IN_W) + 2;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_BYTES - 1);

  // Ring pointer increment with wrap at the ring size.
  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
    ring_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Ring memory, registered read.
  logic [BYTE_W-1:0] ring_mem [RING_BYTES];
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [PTR_W-1:0]  mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // Control registers.
  state_t            state;
  state_t            state_next;
  logic [PTR_W-1:0]  write_ptr;
  logic [PTR_W-1:0]  read_ptr;
  logic [PTR_W-1:0]  pend_wr_ptr;
  logic [PTR_W-1:0]  pend_rd_ptr;
  logic [PTR_W-1:0]  hdr_ptr;
  logic [LEN_W-1:0]  push_rem;
  logic [LEN_W-1:0]  pop_rem;
  logic [LEN_W-1:0]  pop_length;
  logic [1:0]        step_cnt;
  logic [BYTE_W-1:0] hdr_hi;
  logic [23:0]       hdr_low;

  // Input fields.
  logic [REQ_W-1:0]    req_type;
  logic [LEN_IN_W-1:0] msg_len;
  logic [BYTE_W-1:0]   data_byte;
  logic                acc;

  assign req_type  = s_tuser;
  assign msg_len   = s_tdata[15:0];
  assign data_byte = s_tdata[23:16];
  assign s_tready  = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign acc       = s_tvalid && s_tready;

  // Start-push checks against the committed pointers.
  logic [SUM_W-1:0] used;
  logic [SUM_W-1:0] need;
  logic             len_zero;
  logic             len_big;
  logic             no_room;
  logic             push_ok;

  always_comb begin
    if (write_ptr >= read_ptr) begin
      used = SUM_W'(write_ptr) - SUM_W'(read_ptr);
    end else begin
      used = SUM_W'(write_ptr) + SUM_W'(RING_BYTES) - SUM_W'(read_ptr);
    end
    need     = SUM_W'(msg_len) + SUM_W'(4) + used;
    len_zero = (msg_len == '0);
    len_big  = (msg_len > LEN_IN_W'(MAX_MESSAGE_BYTES));
    no_room  = (need >= SUM_W'(RING_BYTES));
    push_ok  = !len_zero && !len_big && !no_room;
  end

  // Header check on the fourth header byte.
  logic [31:0] hdr_word;
  logic        hdr_bad;
  logic        queue_empty;

  assign hdr_word    = {mem_rdata, hdr_low};
  assign hdr_bad     = (hdr_word[31:16] != '0) || (hdr_word[15:0] == '0) ||
                       (hdr_word[15:0] > LEN_IN_W'(MAX_MESSAGE_BYTES));
  assign queue_empty = (read_ptr == write_ptr);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc && req_type == REQ_START && push_ok) begin
          state_next = S_HDR_WR;
        end else if (acc && req_type == REQ_POP) begin
          if (pop_rem != '0) begin
            state_next = S_DATA_RD;
          end else if (!queue_empty) begin
            state_next = S_HDR_RD;
          end
        end
      end
      S_HDR_WR: begin
        if (step_cnt == 2'd3) begin
          state_next = S_IDLE;
        end
      end
      S_HDR_RD: begin
        if (step_cnt == 2'd3) begin
          state_next = hdr_bad ? S_IDLE : S_DATA_RD;
        end
      end
      S_DATA_RD: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Memory port controls and the result word.
  logic              res_load;
  logic [STS_W-1:0]  res_status;
  logic [BYTE_W-1:0] res_byte;
  logic              res_last;

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = pend_wr_ptr;
    mem_wdata  = data_byte;
    mem_raddr  = hdr_ptr;
    res_load   = 1'b0;
    res_status = STS_OK;
    res_byte   = '0;
    res_last   = 1'b0;
    unique case (state)
      S_IDLE: begin
        mem_raddr = (pop_rem != '0) ? pend_rd_ptr : read_ptr;
        if (acc) begin
          res_load = 1'b1;
          unique case (req_type)
            REQ_START: begin
              if (len_zero) begin
                res_status = STS_INVALID;
              end else if (len_big) begin
                res_status = STS_TOO_LARGE;
              end else if (no_room) begin
                res_status = STS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = write_ptr;
                mem_wdata = msg_len[7:0];
              end
            end
            REQ_PUSH: begin
              if (push_rem == '0) begin
                res_status = STS_INVALID;
              end else begin
                mem_we = 1'b1;
              end
            end
            REQ_POP: begin
              // Only an empty queue answers at once; other pops answer after the read.
              if (pop_rem == '0 && queue_empty) begin
                res_status = STS_EMPTY;
              end else begin
                res_load = 1'b0;
              end
            end
            default: begin
              res_status = STS_INVALID;
            end
          endcase
        end
      end
      S_HDR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (step_cnt == 2'd1) ? hdr_hi : '0;
      end
      S_HDR_RD: begin
        if (step_cnt == 2'd3 && hdr_bad) begin
          res_load   = 1'b1;
          res_status = STS_BAD_SIZE;
        end
      end
      S_DATA_RD: begin
        res_load = 1'b1;
        res_byte = mem_rdata;
        res_last = (pop_rem == LEN_W'(1));
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Ring memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= ring_mem[mem_raddr];
  end

  // Pointers, counters and sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_ptr   <= '0;
      read_ptr    <= '0;
      pend_wr_ptr <= '0;
      pend_rd_ptr <= '0;
      hdr_ptr     <= '0;
      push_rem    <= '0;
      pop_rem     <= '0;
      pop_length  <= '0;
      step_cnt    <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (acc && req_type == REQ_START) begin
            // A new start always abandons an open push.
            push_rem <= '0;
            if (push_ok) begin
              pend_wr_ptr <= ring_inc(write_ptr);
              push_rem    <= LEN_W'(msg_len);
              step_cnt    <= 2'd1;
            end
          end else if (acc && req_type == REQ_PUSH && push_rem != '0) begin
            pend_wr_ptr <= ring_inc(pend_wr_ptr);
            push_rem    <= push_rem - LEN_W'(1);
            if (push_rem == LEN_W'(1)) begin
              write_ptr <= ring_inc(pend_wr_ptr);
            end
          end else if (acc && req_type == REQ_POP && pop_rem == '0 && !queue_empty) begin
            hdr_ptr  <= ring_inc(read_ptr);
            step_cnt <= 2'd0;
          end
        end
        S_HDR_WR: begin
          pend_wr_ptr <= ring_inc(pend_wr_ptr);
          step_cnt    <= step_cnt + 2'd1;
        end
        S_HDR_RD: begin
          hdr_ptr  <= ring_inc(hdr_ptr);
          step_cnt <= step_cnt + 2'd1;
          if (step_cnt == 2'd3 && !hdr_bad) begin
            pend_rd_ptr <= hdr_ptr;
            pop_rem     <= LEN_W'(hdr_word[15:0]);
            pop_length  <= LEN_W'(hdr_word[15:0]);
          end
        end
        S_DATA_RD: begin
          pend_rd_ptr <= ring_inc(pend_rd_ptr);
          pop_rem     <= pop_rem - LEN_W'(1);
          if (pop_rem == LEN_W'(1)) begin
            read_ptr <= ring_inc(pend_rd_ptr);
          end
        end
        default: begin
          step_cnt <= '0;
        end
      endcase
    end
  end

  // Header scratch registers.
  always_ff @(posedge clk) begin
    if (acc && req_type == REQ_START) begin
      hdr_hi <= msg_len[15:8];
    end
    if (state == S_HDR_RD && step_cnt != 2'd3) begin
      hdr_low[8*step_cnt +: 8] <= mem_rdata;
    end
  end

  // Output register: holds a finished word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tuser <= res_status;
      m_tdata <= {(res_status == STS_OK && state == S_DATA_RD) ?
                  LEN_IN_W'(pop_length) : LEN_IN_W'(0), res_byte};
      m_tlast <= res_last;
    end
  end

endmodule

/* sv/lrbq_checker.sv */
// Port-level checker for the length-prefixed byte ring queue, with its bind statement.
// Depends on lrbq_pkg and the top level's port list.
module lrbq_checker
  import lrbq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic [23:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [2:0]  m_tuser,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  // A word that ends a message is a good pop carrying a nonzero length.
  a_last_is_pop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == STS_OK && m_tdata[23:8] != 16'd0)
    else $error("last word without a good pop");

  // Error words carry no byte, no length and no last mark.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STS_OK |-> m_tdata == 24'd0 && !m_tlast)
    else $error("error word carries payload");

  // A push byte is answered in the next cycle with ok or invalid, never a pop word.
  a_push_answer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == REQ_PUSH |=>
      m_tvalid && !m_tlast && m_tdata == 24'd0 &&
      (m_tuser == STS_OK || m_tuser == STS_INVALID))
    else $error("push byte answer wrong");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled word changed");

endmodule

bind length_prefixed_byte_ring_queue lrbq_checker u_lrbq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
